/* rtl/bounded_deque_defines.svh */
// Assertion macros shared by the bounded deque RTL.
// No dependencies; the including module must have clk_i and rst_ni in scope.
`ifndef BOUNDED_DEQUE_DEFINES_SVH
`define BOUNDED_DEQUE_DEFINES_SVH

// Clocked check, disabled while reset is asserted.
`define BDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/bdq_pkg.sv */
// Shared types and constants for the bounded deque.
// No dependencies; used by every module of the block except bdq_ram.
package bdq_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW       = $clog2(DEPTH + 1);
  localparam int unsigned LIMW     = (CW > 5) ? CW : 5;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned FILL_W   = 5;
  localparam int unsigned CAP_W    = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT
  } bdq_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture action and word
    logic wr_en;    // write slot
    logic rd_en;    // read slot
    logic upd;      // commit head/count
    logic out_now;  // load result from current flags
    logic out_mem;  // load result from read data
  } bdq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_push;
    logic full;
    logic empty;
  } bdq_stat_t;

endpackage

/* rtl/bdq_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bdq_datapath.sv */
// Deque datapath: head/count registers, capacity register, slot RAM, result registers.
// Depends on bdq_pkg and bdq_ram.
module bdq_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bdq_pkg::bdq_cmd_t                   cmd_i,
  output bdq_pkg::bdq_stat_t                  stat_o,
  input  logic                                cfg_we_i,
  input  logic [bdq_pkg::CAP_W-1:0]           cfg_wdata_i,
  input  logic [1:0]                          action_i,
  input  logic signed [bdq_pkg::WORD_W-1:0]   push_value_i,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic signed [bdq_pkg::WORD_W-1:0]   popped_value_o,
  output logic [bdq_pkg::FILL_W-1:0]          fill_count_o
);

  localparam int unsigned AW = bdq_pkg::AW;
  localparam int unsigned CW = bdq_pkg::CW;

  bdq_pkg::action_e                 act_q;
  logic [bdq_pkg::WORD_W-1:0]       val_q;
  logic [AW-1:0]                    head_q, head_d;
  logic [CW-1:0]                    count_q, count_d;
  logic [bdq_pkg::CAP_W-1:0]        cap_q;
  logic                             done_q;
  bdq_pkg::status_e                 status_q;
  logic [bdq_pkg::WORD_W-1:0]       popped_q;
  logic [bdq_pkg::FILL_W-1:0]       fill_q;

  logic [bdq_pkg::LIMW-1:0]         cap_ext, depth_ext, limit;
  logic [AW:0]                      off, sum, sum_wrap;
  logic [AW-1:0]                    head_dec, addr;
  logic [CW-1:0]                    count_next;
  logic [bdq_pkg::WORD_W-1:0]       rdata;
  bdq_pkg::status_e                 status_now;

  // effective limit = min(capacity, DEPTH)
  assign cap_ext   = bdq_pkg::LIMW'(cap_q);
  assign depth_ext = bdq_pkg::LIMW'(bdq_pkg::DEPTH);
  assign limit     = (cap_ext < depth_ext) ? cap_ext : depth_ext;

  assign stat_o.is_push = (act_q == bdq_pkg::ACT_PUSH_FRONT) ||
                          (act_q == bdq_pkg::ACT_PUSH_BACK);
  assign stat_o.full    = (bdq_pkg::LIMW'(count_q) >= limit);
  assign stat_o.empty   = (count_q == '0);

  assign head_dec = (head_q == '0) ? AW'(bdq_pkg::DEPTH - 1) : head_q - AW'(1);

  // ring index: head + offset, one conditional subtract
  always_comb begin
    case (act_q)
      bdq_pkg::ACT_PUSH_BACK: off = (AW+1)'(count_q);
      bdq_pkg::ACT_POP_BACK:  off = (AW+1)'(count_q) - (AW+1)'(1);
      default:                off = (AW+1)'(1);
    endcase
  end

  assign sum      = {1'b0, head_q} + off;
  assign sum_wrap = (sum >= (AW+1)'(bdq_pkg::DEPTH)) ? sum - (AW+1)'(bdq_pkg::DEPTH) : sum;

  always_comb begin
    head_d     = head_q;
    count_next = count_q + CW'(1);
    addr       = head_q;
    case (act_q)
      bdq_pkg::ACT_PUSH_FRONT: begin
        addr   = head_dec;
        head_d = head_dec;
      end
      bdq_pkg::ACT_PUSH_BACK: begin
        addr = sum_wrap[AW-1:0];
      end
      bdq_pkg::ACT_POP_FRONT: begin
        addr       = head_q;
        head_d     = sum_wrap[AW-1:0];
        count_next = count_q - CW'(1);
      end
      bdq_pkg::ACT_POP_BACK: begin
        addr       = sum_wrap[AW-1:0];
        count_next = count_q - CW'(1);
      end
      default: begin
        addr = head_q;
      end
    endcase
  end

  assign count_d = cmd_i.upd ? count_next : count_q;

  always_comb begin
    if (stat_o.is_push) begin
      status_now = stat_o.full ? bdq_pkg::ST_FULL : bdq_pkg::ST_DONE;
    end else begin
      status_now = stat_o.empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_DONE;
    end
  end

  bdq_ram #(
    .WIDTH (bdq_pkg::WORD_W),
    .DEPTH (bdq_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (cmd_i.wr_en | cmd_i.rd_en),
    .we_i    (cmd_i.wr_en),
    .addr_i  (addr),
    .wdata_i (val_q),
    .rdata_o (rdata)
  );

  // item capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= bdq_pkg::action_e'(action_i);
      val_q <= push_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      cap_q   <= bdq_pkg::CAP_RESET;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.upd) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
      done_q <= cmd_i.out_now | cmd_i.out_mem;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_now) begin
      status_q <= status_now;
      popped_q <= '0;
      fill_q   <= bdq_pkg::FILL_W'(count_d);
    end else if (cmd_i.out_mem) begin
      status_q <= bdq_pkg::ST_DONE;
      popped_q <= rdata;
      fill_q   <= bdq_pkg::FILL_W'(count_q);
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign fill_count_o   = fill_q;

endmodule

/* rtl/bdq_ctrl.sv */
// Deque controller: sequences capture, slot access and result load.
// Depends on bdq_pkg and bounded_deque_defines.svh.
`include "bounded_deque_defines.svh"

module bdq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  bdq_pkg::bdq_stat_t stat_i,
  output bdq_pkg::bdq_cmd_t  cmd_o
);

  bdq_pkg::bdq_state_e state_q, state_d;
  logic ok_push, ok_pop;

  assign ok_push = stat_i.is_push && !stat_i.full;
  assign ok_pop  = !stat_i.is_push && !stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bdq_pkg::S_IDLE: begin
        if (start) state_d = bdq_pkg::S_EXEC;
      end
      bdq_pkg::S_EXEC: begin
        state_d = ok_pop ? bdq_pkg::S_RDWAIT : bdq_pkg::S_IDLE;
      end
      bdq_pkg::S_RDWAIT: begin
        state_d = bdq_pkg::S_IDLE;
      end
      default: begin
        state_d = bdq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      bdq_pkg::S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      bdq_pkg::S_EXEC: begin
        cmd_o.wr_en   = ok_push;
        cmd_o.rd_en   = ok_pop;
        cmd_o.upd     = ok_push | ok_pop;
        cmd_o.out_now = !ok_pop;
      end
      bdq_pkg::S_RDWAIT: begin
        cmd_o.out_mem = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `BDQ_ASSERT(a_accept_busy, ((start && !busy) |=> busy), "accepted item did not raise busy")
  `BDQ_ASSERT_ALWAYS(a_one_access, (!(cmd_o.wr_en && cmd_o.rd_en)), "slot read and write together")
  `BDQ_ASSERT(a_read_then_out, (cmd_o.rd_en |=> cmd_o.out_mem), "slot read not followed by result")
  `BDQ_ASSERT(a_one_result, ((cmd_o.out_now || cmd_o.out_mem) |=> !(cmd_o.out_now || cmd_o.out_mem)), "two results for one item")

endmodule

/* rtl/bounded_deque.sv */
// Bounded double-ended queue of signed 32-bit words held in a ring buffer.
// Depends on bdq_pkg, bdq_ctrl, bdq_datapath (which holds bdq_ram).
//
// Usage:
//   Command channel: drive action_i / push_value_i and raise start; the word
//   is taken at a rising edge with start high and busy low.
//   Actions: push front, push back, pop front, pop back. A push at the
//   effective capacity, min(capacity, DEPTH), is refused as full; a pop on
//   an empty deque is refused as empty.
//   Result channel: done_o is high for exactly one cycle with status_o,
//   popped_value_o (zero unless a pop succeeded) and fill_count_o, the
//   count after the action. The receiver has no way to stall it.
//   Sequencing: pushes and refused actions load the result in the execute
//   state; a successful pop adds a read-wait state for the registered read
//   of the slot RAM. busy drops in the cycle done_o is high, so a new word
//   is taken only once the previous action is finished.
//   Configuration: cfg_we_i writes the capacity register from cfg_wdata_i;
//   write only while the block is idle.
//   Reset (rst_ni low, async): deque empty, head at slot 0, capacity 16.
//   Slot contents are not cleared; only written slots are ever read.
module bounded_deque (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         action_i,
  input  logic signed [bdq_pkg::WORD_W-1:0]  push_value_i,
  input  logic                               cfg_we_i,
  input  logic [bdq_pkg::CAP_W-1:0]          cfg_wdata_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic signed [bdq_pkg::WORD_W-1:0]  popped_value_o,
  output logic [bdq_pkg::FILL_W-1:0]         fill_count_o
);

  bdq_pkg::bdq_cmd_t  cmd;
  bdq_pkg::bdq_stat_t stat;

  // sequencing: idle -> execute -> (read wait on a good pop) -> idle
  bdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // pointers, count, capacity, slots and result registers
  bdq_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .action_i       (action_i),
    .push_value_i   (push_value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .fill_count_o   (fill_count_o)
  );

endmodule
